@@ rtl/core/piola_mapping_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Piola mapping unit assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PIOLA_MAPPING_UNIT_MACROS_SVH
`define PIOLA_MAPPING_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every edge.
`define PMU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define PMU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMU_ASSERT(name, prop, msg)
`define PMU_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ rtl/core/piola_pkg.sv @@
// ----------------------------------------------------------------------------
// Piola mapping package
// Shared constants, codes and types of the Piola mapping unit.
// ----------------------------------------------------------------------------
package piola_pkg;

  localparam int MaxDim   = 3;
  localparam int FracBits = 16;
  localparam int ValW     = 32;
  localparam int IdxW     = 2;
  // rounded products stay within 2^46 in magnitude, three of them below 2^48
  localparam int AccW     = 50;
  localparam int CntW     = 4;

  localparam logic [2:0] FuncLoadJ   = 3'd0;
  localparam logic [2:0] FuncLoadK   = 3'd1;
  localparam logic [2:0] FuncLoadDet = 3'd2;
  localparam logic [2:0] FuncLoadDat = 3'd3;
  localparam logic [2:0] FuncCompute = 3'd4;

  localparam logic [2:0] KindIdentity = 3'd0;
  localparam logic [2:0] KindCov      = 3'd1;
  localparam logic [2:0] KindContra   = 3'd2;
  localparam logic [2:0] KindDblCov   = 3'd3;
  localparam logic [2:0] KindDblCon   = 3'd4;

  localparam logic [1:0] ErrOk      = 2'd0;
  localparam logic [1:0] ErrZeroDet = 2'd1;
  localparam logic [1:0] ErrSat     = 2'd2;

  localparam logic [1:0] RegMapKind = 2'd0;
  localparam logic [1:0] RegGeoDim  = 2'd1;
  localparam logic [1:0] RegTopoDim = 2'd2;

  typedef struct packed {
    logic            done;
    logic            sat;
    logic [ValW-1:0] value;
  } div_rsp_t;

endpackage

@@ rtl/core/piola_mapping_unit.sv @@
// ----------------------------------------------------------------------------
// Piola mapping unit
// Maps reference finite element values to physical space (covariant and
// contravariant Piola transforms) on one shared multiplier and divider.
// ----------------------------------------------------------------------------
// A compute item keeps the block busy: every mapped entry is a dot product of
// length t run on one shared 32x32 multiplier, each product passing through
// the multiply and accumulate states, followed by a bit-serial divider in the
// contravariant modes. Double modes first build an intermediate matrix the
// same way. Identity emits one element per cycle while the output register is
// free. Results leave through an output register and the sequencer waits on
// it only when that register still holds an unaccepted item. Configuration
// must be written only while the block is idle; the block does not enforce it.
`include "piola_mapping_unit_macros.svh"

module piola_mapping_unit import piola_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // row[1:0], col[3:2], value[35:4], zero fill [39:36]
  input  logic [39:0] s_axis_tdata_i,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_value[31:0], out_row[33:32], out_col[35:34], zero fill [39:36]
  output logic [39:0] m_axis_tdata_o,
  // error[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_FIN  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_PUT  = 4'd5;
  localparam logic [3:0] S_IDN  = 4'd6;
  localparam logic [3:0] S_ZERO = 4'd7;

  localparam logic signed [AccW-1:0] SatMax = AccW'(64'sh7fffffff);
  localparam logic signed [AccW-1:0] SatMin = -AccW'(64'sh80000000);

  logic [2:0] map_kind_q;
  logic [1:0] geo_dim_q, topo_dim_q;

  logic [ValW-1:0] jac_q [MaxDim][MaxDim];
  logic [ValW-1:0] inv_q [MaxDim][MaxDim];
  logic [ValW-1:0] dat_q [MaxDim][MaxDim];
  logic [ValW-1:0] mid_q [MaxDim][MaxDim];
  logic            msat_q [MaxDim][MaxDim];
  logic [ValW-1:0] det_q;
  logic [CntW-1:0] dlen_q;

  logic [3:0]      state_q;
  logic            mid_phase_q;
  logic [IdxW-1:0] x_q, y_q, k_q;
  logic [CntW-1:0] e_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [2*ValW-1:0] prod_q;
  logic            any_q;
  logic [ValW-1:0] val_q;
  logic            sat_q;

  logic            out_valid_q, out_last_q;
  logic [ValW-1:0] out_value_q;
  logic [IdxW-1:0] out_row_q, out_col_q;
  logic [1:0]      out_err_q;

  logic [2:0]      s_func;
  logic [IdxW-1:0] s_row, s_col;
  logic [ValW-1:0] s_value;
  logic            s_fire, out_free;
  logic [1:0]      g, t;

  assign s_func  = s_axis_tuser_i;
  assign s_row   = s_axis_tdata_i[1:0];
  assign s_col   = s_axis_tdata_i[3:2];
  assign s_value = s_axis_tdata_i[35:4];

  assign s_axis_tready_o = state_q == S_IDLE;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign g = (geo_dim_q == 2'd0) ? 2'd1 : geo_dim_q;
  assign t = (topo_dim_q == 2'd0) ? 2'd1 : topo_dim_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_kind_q <= KindIdentity;
      geo_dim_q  <= 2'd3;
      topo_dim_q <= 2'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMapKind: map_kind_q <= cfg_data_i;
        RegGeoDim:  geo_dim_q  <= cfg_data_i[1:0];
        RegTopoDim: topo_dim_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Load items
  logic            load_ok;
  logic [CntW-1:0] load_len, load_len_cap;

  assign load_ok      = s_fire && s_func <= FuncLoadDat && s_row < IdxW'(MaxDim)
                        && s_col < IdxW'(MaxDim);
  assign load_len     = CntW'(s_col) * CntW'(t) + CntW'(s_row) + CntW'(1);
  assign load_len_cap = (load_len > CntW'(MaxDim*MaxDim)) ? CntW'(MaxDim*MaxDim) : load_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxDim; r++) begin
        for (int c = 0; c < MaxDim; c++) begin
          jac_q[r][c] <= '0;
          inv_q[r][c] <= '0;
          dat_q[r][c] <= '0;
        end
      end
      det_q  <= '0;
      dlen_q <= '0;
    end else if (load_ok) begin
      case (s_func)
        FuncLoadJ:   jac_q[s_row][s_col] <= s_value;
        FuncLoadK:   inv_q[s_row][s_col] <= s_value;
        FuncLoadDet: det_q <= s_value;
        default: begin
          dat_q[s_row][s_col] <= s_value;
          if (load_len_cap > dlen_q) dlen_q <= load_len_cap;
        end
      endcase
    end
  end

  // Operand selection for the shared multiplier
  logic [ValW-1:0] opa, opb;
  logic            msat_sel;

  always_comb begin
    opa      = '0;
    opb      = '0;
    msat_sel = 1'b0;
    case (map_kind_q)
      KindCov: begin
        opa = inv_q[k_q][x_q];
        opb = dat_q[k_q][0];
      end
      KindContra: begin
        opa = jac_q[x_q][k_q];
        opb = dat_q[k_q][0];
      end
      KindDblCov: begin
        if (mid_phase_q) begin
          opa = dat_q[x_q][k_q];
          opb = inv_q[k_q][y_q];
        end else begin
          opa      = inv_q[k_q][x_q];
          opb      = mid_q[k_q][y_q];
          msat_sel = msat_q[k_q][y_q];
        end
      end
      default: begin
        if (mid_phase_q) begin
          opa = jac_q[x_q][k_q];
          opb = dat_q[k_q][y_q];
        end else begin
          opa      = mid_q[x_q][k_q];
          opb      = jac_q[y_q][k_q];
          msat_sel = msat_q[x_q][k_q];
        end
      end
    endcase
  end

  // Round the registered product half away from zero
  logic [2*ValW-1:0]      prod_mag;
  logic [2*ValW-1:0]      prod_rnd;
  logic signed [AccW-1:0] term;

  assign prod_mag = prod_q[2*ValW-1] ? (2*ValW)'(-prod_q) : (2*ValW)'(prod_q);
  assign prod_rnd = (prod_mag + (2*ValW)'(1 << (FracBits-1))) >> FracBits;
  assign term     = prod_q[2*ValW-1] ? -$signed(prod_rnd[AccW-1:0])
                                     : $signed(prod_rnd[AccW-1:0]);

  // Element bounds and divider use
  logic [1:0] xlim, ylim;
  logic       use_div, last_elem;
  logic [CntW-1:0] idn_cnt, zero_cnt;
  logic [CntW-1:0] dl1, tt;

  always_comb begin
    xlim = g;
    ylim = g;
    if (mid_phase_q) begin
      xlim = (map_kind_q == KindDblCov) ? t : g;
      ylim = (map_kind_q == KindDblCov) ? g : t;
    end else if (map_kind_q == KindCov || map_kind_q == KindContra) begin
      ylim = 2'd1;
    end
  end

  assign use_div   = map_kind_q == KindDblCon || (map_kind_q == KindContra && !mid_phase_q);
  assign last_elem = x_q == xlim - 1'b1 && y_q == ylim - 1'b1;
  assign dl1       = (dlen_q == '0) ? CntW'(1) : dlen_q;
  assign tt        = CntW'(t) * CntW'(t);
  assign idn_cnt   = (dl1 > tt) ? tt : dl1;
  assign zero_cnt  = (map_kind_q == KindContra) ? CntW'(g) : CntW'(g) * CntW'(g);

  // Shared divider
  div_rsp_t div_rsp;
  logic     div_start;

  assign div_start = state_q == S_FIN && use_div;

  piola_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (det_q),
    .rsp_o   (div_rsp)
  );

  // Sequencer
  logic            emit;
  logic [ValW-1:0] emit_value;
  logic [1:0]      emit_err;
  logic            emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mid_phase_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      k_q         <= '0;
      e_q         <= '0;
      any_q       <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_fire && s_func == FuncCompute) begin
            x_q   <= '0;
            y_q   <= '0;
            k_q   <= '0;
            e_q   <= '0;
            any_q <= 1'b0;
            if (map_kind_q == KindIdentity) begin
              state_q <= S_IDN;
            end else if ((map_kind_q == KindContra || map_kind_q == KindDblCon)
                         && det_q == '0) begin
              state_q <= S_ZERO;
            end else if (map_kind_q == KindCov || map_kind_q == KindContra) begin
              mid_phase_q <= 1'b0;
              state_q     <= S_MUL;
            end else if (map_kind_q == KindDblCov || map_kind_q == KindDblCon) begin
              mid_phase_q <= 1'b1;
              state_q     <= S_MUL;
            end
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          any_q <= any_q | msat_sel;
          if (k_q == t - 1'b1) begin
            state_q <= S_FIN;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_FIN: state_q <= use_div ? S_DIV : S_PUT;
        S_DIV: begin
          if (div_rsp.done) state_q <= S_PUT;
        end
        S_PUT: begin
          if (mid_phase_q || out_free) begin
            k_q   <= '0;
            any_q <= 1'b0;
            if (last_elem) begin
              x_q <= '0;
              y_q <= '0;
              if (mid_phase_q) begin
                mid_phase_q <= 1'b0;
                state_q     <= S_MUL;
              end else begin
                state_q <= S_IDLE;
              end
            end else begin
              state_q <= S_MUL;
              if (x_q == xlim - 1'b1) begin
                x_q <= '0;
                y_q <= y_q + 1'b1;
              end else begin
                x_q <= x_q + 1'b1;
              end
            end
          end
        end
        S_IDN, S_ZERO: begin
          if (out_free) begin
            e_q <= e_q + 1'b1;
            if (e_q == ((state_q == S_IDN) ? idn_cnt : zero_cnt) - CntW'(1)) begin
              state_q <= S_IDLE;
            end else if (x_q == ((state_q == S_IDN) ? t : g) - 1'b1) begin
              x_q <= '0;
              y_q <= y_q + 1'b1;
            end else begin
              x_q <= x_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_q <= $signed(opa) * $signed(opb);
    end
    if (state_q == S_IDLE || state_q == S_PUT) begin
      acc_q <= '0;
    end else if (state_q == S_ACC) begin
      acc_q <= acc_q + term;
    end
    if (state_q == S_FIN && !use_div) begin
      if (acc_q > SatMax) begin
        val_q <= SatMax[ValW-1:0];
        sat_q <= 1'b1;
      end else if (acc_q < SatMin) begin
        val_q <= SatMin[ValW-1:0];
        sat_q <= 1'b1;
      end else begin
        val_q <= acc_q[ValW-1:0];
        sat_q <= 1'b0;
      end
    end else if (state_q == S_DIV && div_rsp.done) begin
      val_q <= div_rsp.value;
      sat_q <= div_rsp.sat;
    end
    if (state_q == S_PUT && mid_phase_q) begin
      mid_q[x_q][y_q]  <= val_q;
      msat_q[x_q][y_q] <= sat_q;
    end
  end

  // Result item into the output register
  always_comb begin
    emit       = 1'b0;
    emit_value = '0;
    emit_err   = ErrOk;
    emit_last  = 1'b0;
    case (state_q)
      S_PUT: begin
        emit       = !mid_phase_q && out_free;
        emit_value = val_q;
        emit_err   = (sat_q || any_q) ? ErrSat : ErrOk;
        emit_last  = last_elem;
      end
      S_IDN: begin
        emit       = out_free;
        emit_value = dat_q[x_q][y_q];
        emit_last  = e_q == idn_cnt - CntW'(1);
      end
      S_ZERO: begin
        emit      = out_free;
        emit_err  = ErrZeroDet;
        emit_last = e_q == zero_cnt - CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= emit_value;
      out_row_q   <= x_q;
      out_col_q   <= y_q;
      out_err_q   <= emit_err;
      out_last_q  <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_col_q, out_row_q, out_value_q};
  assign m_axis_tuser_o  = out_err_q;
  assign m_axis_tlast_o  = out_last_q;

  `PMU_ASSERT(a_div_done_in_div, div_rsp.done |-> state_q == S_DIV, "divider done outside wait")
  `PMU_ASSERT(a_zero_det_value, (m_axis_tvalid_o && out_err_q == ErrZeroDet) |-> out_value_q == '0, "zero determinant item with nonzero value")
  `PMU_ASSERT_NEXT(a_compute_busy, s_fire && s_func == FuncCompute && map_kind_q <= KindDblCon, !s_axis_tready_o, "compute item did not start")

endmodule

@@ rtl/core/piola_divider.sv @@
// ----------------------------------------------------------------------------
// Piola fixed-point divider
// Computes n * 2^FracBits / d rounded half away from zero, saturated to 32 bits,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module piola_divider import piola_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AccW-1:0] num_i,
  input  logic signed [ValW-1:0] den_i,
  output div_rsp_t               rsp_o
);

  localparam int NumW = AccW + FracBits;
  localparam int StepW = $clog2(ValW + 1);

  logic              busy_q;
  logic [StepW-1:0]  cnt_q;
  logic [ValW-1:0]   rem_q, nlo_q, quo_q, md_q;
  logic              neg_q, ovf_q;

  logic [AccW-1:0]   mn;
  logic [ValW-1:0]   md;
  logic [NumW-1:0]   num_full;
  logic [NumW-ValW-1:0] num_hi;
  logic [ValW:0]     trial;
  logic              ge;

  assign mn       = num_i[AccW-1] ? AccW'(-num_i) : AccW'(num_i);
  assign md       = den_i[ValW-1] ? ValW'(-den_i) : ValW'(den_i);
  assign num_full = {mn, {FracBits{1'b0}}} + NumW'(md >> 1);
  assign num_hi   = num_full[NumW-1:ValW];

  assign trial = {rem_q, nlo_q[ValW-1]};
  assign ge    = trial >= {1'b0, md_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= StepW'(ValW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      md_q  <= md;
      neg_q <= num_i[AccW-1] != den_i[ValW-1];
      ovf_q <= num_hi >= (NumW-ValW)'(md);
      rem_q <= num_hi[ValW-1:0];
      nlo_q <= num_full[ValW-1:0];
      quo_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? ValW'(trial - {1'b0, md_q}) : trial[ValW-1:0];
      nlo_q <= {nlo_q[ValW-2:0], 1'b0};
      quo_q <= {quo_q[ValW-2:0], ge};
    end
  end

  localparam logic [ValW-1:0] MinMag = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] MaxPos = {1'b0, {(ValW-1){1'b1}}};

  always_comb begin
    rsp_o.done  = busy_q && cnt_q == '0;
    rsp_o.sat   = 1'b0;
    rsp_o.value = '0;
    if (ovf_q) begin
      rsp_o.sat   = 1'b1;
      rsp_o.value = neg_q ? MinMag : MaxPos;
    end else if (neg_q) begin
      if (quo_q > MinMag) begin
        rsp_o.sat   = 1'b1;
        rsp_o.value = MinMag;
      end else begin
        rsp_o.value = ValW'(-quo_q);
      end
    end else if (quo_q > MaxPos) begin
      rsp_o.sat   = 1'b1;
      rsp_o.value = MaxPos;
    end else begin
      rsp_o.value = quo_q;
    end
  end

endmodule
